[hdl/rvdec_pkg.sv]
// Shared opcodes, operation numbers and the decode result type of the RV64IMF decoder.
package rvdec_pkg;

  // Major opcodes, bits 6:0 of the instruction word.
  localparam logic [6:0] OPC_LUI      = 7'b0110111;
  localparam logic [6:0] OPC_AUIPC    = 7'b0010111;
  localparam logic [6:0] OPC_JAL      = 7'b1101111;
  localparam logic [6:0] OPC_JALR     = 7'b1100111;
  localparam logic [6:0] OPC_BRANCH   = 7'b1100011;
  localparam logic [6:0] OPC_LOAD     = 7'b0000011;
  localparam logic [6:0] OPC_STORE    = 7'b0100011;
  localparam logic [6:0] OPC_OP_IMM   = 7'b0010011;
  localparam logic [6:0] OPC_OP       = 7'b0110011;
  localparam logic [6:0] OPC_SYSTEM   = 7'h73;
  localparam logic [6:0] OPC_OP_IMM32 = 7'b0011011;
  localparam logic [6:0] OPC_OP32     = 7'b0111011;
  localparam logic [6:0] OPC_LOAD_FP  = 7'b0000111;
  localparam logic [6:0] OPC_STORE_FP = 7'b0100111;
  localparam logic [6:0] OPC_FMADD    = 7'b1000011;
  localparam logic [6:0] OPC_FMSUB    = 7'b1000111;
  localparam logic [6:0] OPC_FNMSUB   = 7'b1001011;
  localparam logic [6:0] OPC_FNMADD   = 7'b1001111;
  localparam logic [6:0] OPC_OP_FP    = 7'b1010011;

  // The one SYSTEM word that is decoded.
  localparam logic [31:0] ECALL_WORD = 32'h0000_0073;

  // Function codes that are decoded: the float group and the integer M and base groups.
  localparam logic [6:0] F7_FADD  = 7'h00;
  localparam logic [6:0] F7_FSUB  = 7'h04;
  localparam logic [6:0] F7_FMUL  = 7'h08;
  localparam logic [6:0] F7_FDIV  = 7'h0C;
  localparam logic [6:0] F7_FCVT  = 7'b1101000;
  localparam logic [6:0] F7_MULDIV = 7'h01;
  localparam logic [6:0] F7_BASE   = 7'h00;

  // Dense operation numbers.
  localparam logic [6:0] OP_LUI       = 7'd0;
  localparam logic [6:0] OP_AUIPC     = 7'd1;
  localparam logic [6:0] OP_JAL       = 7'd2;
  localparam logic [6:0] OP_JALR      = 7'd3;
  localparam logic [6:0] OP_BEQ       = 7'd4;
  localparam logic [6:0] OP_BNE       = 7'd5;
  localparam logic [6:0] OP_BLT       = 7'd6;
  localparam logic [6:0] OP_BGE       = 7'd7;
  localparam logic [6:0] OP_BLTU      = 7'd8;
  localparam logic [6:0] OP_BGEU      = 7'd9;
  localparam logic [6:0] OP_LB        = 7'd10;
  localparam logic [6:0] OP_LH        = 7'd11;
  localparam logic [6:0] OP_LW        = 7'd12;
  localparam logic [6:0] OP_LD        = 7'd13;
  localparam logic [6:0] OP_LBU       = 7'd14;
  localparam logic [6:0] OP_LHU       = 7'd15;
  localparam logic [6:0] OP_LWU       = 7'd16;
  localparam logic [6:0] OP_SB        = 7'd17;
  localparam logic [6:0] OP_SH        = 7'd18;
  localparam logic [6:0] OP_SW        = 7'd19;
  localparam logic [6:0] OP_SD        = 7'd20;
  localparam logic [6:0] OP_ADDI      = 7'd21;
  localparam logic [6:0] OP_SLLI      = 7'd22;
  localparam logic [6:0] OP_SLTI      = 7'd23;
  localparam logic [6:0] OP_SLTIU     = 7'd24;
  localparam logic [6:0] OP_XORI      = 7'd25;
  localparam logic [6:0] OP_SRAI      = 7'd26;
  localparam logic [6:0] OP_SRLI      = 7'd27;
  localparam logic [6:0] OP_ORI       = 7'd28;
  localparam logic [6:0] OP_ANDI      = 7'd29;
  localparam logic [6:0] OP_MUL       = 7'd30;
  localparam logic [6:0] OP_SUB       = 7'd38;
  localparam logic [6:0] OP_ADD       = 7'd39;
  localparam logic [6:0] OP_SLL       = 7'd40;
  localparam logic [6:0] OP_SLT       = 7'd41;
  localparam logic [6:0] OP_SLTU      = 7'd42;
  localparam logic [6:0] OP_XOR       = 7'd43;
  localparam logic [6:0] OP_SRA       = 7'd44;
  localparam logic [6:0] OP_SRL       = 7'd45;
  localparam logic [6:0] OP_OR        = 7'd46;
  localparam logic [6:0] OP_AND       = 7'd47;
  localparam logic [6:0] OP_ECALL     = 7'd48;
  localparam logic [6:0] OP_ADDIW     = 7'd49;
  localparam logic [6:0] OP_SLLIW     = 7'd50;
  localparam logic [6:0] OP_SRAIW     = 7'd51;
  localparam logic [6:0] OP_SRLIW     = 7'd52;
  localparam logic [6:0] OP_MULW      = 7'd53;
  localparam logic [6:0] OP_SUBW      = 7'd54;
  localparam logic [6:0] OP_ADDW      = 7'd55;
  localparam logic [6:0] OP_SLLW      = 7'd56;
  localparam logic [6:0] OP_DIVW      = 7'd57;
  localparam logic [6:0] OP_DIVUW     = 7'd58;
  localparam logic [6:0] OP_SRAW      = 7'd59;
  localparam logic [6:0] OP_SRLW      = 7'd60;
  localparam logic [6:0] OP_REMW      = 7'd61;
  localparam logic [6:0] OP_REMUW     = 7'd62;
  localparam logic [6:0] OP_FLW       = 7'd63;
  localparam logic [6:0] OP_FSW       = 7'd64;
  localparam logic [6:0] OP_FMADD_S   = 7'd65;
  localparam logic [6:0] OP_FMSUB_S   = 7'd66;
  localparam logic [6:0] OP_FNMSUB_S  = 7'd67;
  localparam logic [6:0] OP_FNMADD_S  = 7'd68;
  localparam logic [6:0] OP_FADD_S    = 7'd69;
  localparam logic [6:0] OP_FSUB_S    = 7'd70;
  localparam logic [6:0] OP_FMUL_S    = 7'd71;
  localparam logic [6:0] OP_FDIV_S    = 7'd72;
  localparam logic [6:0] OP_FCVT_S_W  = 7'd73;
  localparam logic [6:0] OP_LAST      = 7'd76;

  // One decoded request as it leaves the decode logic.
  typedef struct packed {
    logic [6:0]         operation;
    logic [4:0]         dest_reg;
    logic [4:0]         src1_reg;
    logic [4:0]         src2_reg;
    logic [4:0]         src3_reg;
    logic signed [31:0] immediate;
    logic               illegal;
  } dec_result_t;

endpackage

[hdl/rv64imf_instruction_decoder.sv]
// Top level of the RV64IMF decoder: input register, decode logic and result register.
//
// The decoder takes one 32-bit instruction per clock cycle while in_stall is low and returns one
// decoded result for each. A request is captured in an input register, decoded by a single layer
// of combinational logic and held in a result register. Each register advances when its
// successor can take a request, so one instruction per cycle flows through for as long as the
// output side takes results; in_stall is raised only when both registers hold requests and
// out_stall is high. The block has no configuration and no state beyond the two pipeline
// registers; reset empties them.
module rv64imf_instruction_decoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        instruction,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [6:0]         operation,
  output logic [4:0]         dest_reg,
  output logic [4:0]         src1_reg,
  output logic [4:0]         src2_reg,
  output logic [4:0]         src3_reg,
  output logic signed [31:0] immediate,
  output logic               illegal
);

  logic                   in_reg_valid;
  logic [31:0]            in_reg;
  logic                   res_advance;
  logic                   in_advance;
  rvdec_pkg::dec_result_t dec;
  rvdec_pkg::dec_result_t res;

  // Handshake: each register moves when its successor can take a request.
  assign res_advance = ~out_valid | ~out_stall;
  assign in_advance  = ~in_reg_valid | res_advance;
  assign in_stall    = ~in_advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_advance) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_advance && in_valid) begin
      in_reg <= instruction;
    end
  end

  // Decode logic.
  rvdec_core u_core (
    .instruction (in_reg),
    .result      (dec)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_advance) begin
      out_valid <= in_reg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_advance && in_reg_valid) begin
      res <= dec;
    end
  end

  assign operation = res.operation;
  assign dest_reg  = res.dest_reg;
  assign src1_reg  = res.src1_reg;
  assign src2_reg  = res.src2_reg;
  assign src3_reg  = res.src3_reg;
  assign immediate = res.immediate;
  assign illegal   = res.illegal;

endmodule

[hdl/rvdec_core.sv]
// Combinational decode of one instruction word into operation, registers and immediate.
module rvdec_core (
  input  logic [31:0]              instruction,
  output rvdec_pkg::dec_result_t   result
);

  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [4:0]  rs2;
  logic        alt;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_u;
  logic [31:0] imm_j;
  logic [31:0] shamt;
  logic        legal;
  logic [6:0]  op;
  logic [31:0] imm;

  // Field extraction and the immediates of every format.
  assign opc   = instruction[6:0];
  assign f3    = instruction[14:12];
  assign f7    = instruction[31:25];
  assign rs2   = instruction[24:20];
  assign alt   = instruction[30];
  assign imm_i = {{21{instruction[31]}}, instruction[30:20]};
  assign imm_s = {{21{instruction[31]}}, instruction[30:25], instruction[11:7]};
  assign imm_b = {{20{instruction[31]}}, instruction[7], instruction[30:25],
                  instruction[11:8], 1'b0};
  assign imm_u = {instruction[31:12], 12'b0};
  assign imm_j = {{12{instruction[31]}}, instruction[19:12], instruction[20],
                  instruction[30:21], 1'b0};
  assign shamt = {26'b0, instruction[25:20]};

  // Opcode and function-field decode.
  always_comb begin
    legal = 1'b1;
    op    = rvdec_pkg::OP_LUI;
    imm   = 32'b0;
    case (opc)
      rvdec_pkg::OPC_LUI: begin
        op  = rvdec_pkg::OP_LUI;
        imm = imm_u;
      end
      rvdec_pkg::OPC_AUIPC: begin
        op  = rvdec_pkg::OP_AUIPC;
        imm = imm_u;
      end
      rvdec_pkg::OPC_JAL: begin
        op  = rvdec_pkg::OP_JAL;
        imm = imm_j;
      end
      rvdec_pkg::OPC_JALR: begin
        op  = rvdec_pkg::OP_JALR;
        imm = imm_i;
      end
      rvdec_pkg::OPC_BRANCH: begin
        imm = imm_b;
        case (f3)
          3'd0: op = rvdec_pkg::OP_BEQ;
          3'd1: op = rvdec_pkg::OP_BNE;
          3'd4: op = rvdec_pkg::OP_BLT;
          3'd5: op = rvdec_pkg::OP_BGE;
          3'd6: op = rvdec_pkg::OP_BLTU;
          3'd7: op = rvdec_pkg::OP_BGEU;
          default: legal = 1'b0;
        endcase
      end
      rvdec_pkg::OPC_LOAD: begin
        imm = imm_i;
        // Loads are numbered in funct3 order; funct3 7 has no load.
        if (f3 == 3'd7) begin
          legal = 1'b0;
        end else begin
          op = rvdec_pkg::OP_LB + {4'b0, f3};
        end
      end
      rvdec_pkg::OPC_STORE: begin
        imm = imm_s;
        if (f3[2]) begin
          legal = 1'b0;
        end else begin
          op = rvdec_pkg::OP_SB + {4'b0, f3};
        end
      end
      rvdec_pkg::OPC_OP_IMM: begin
        imm = imm_i;
        case (f3)
          3'd0: op = rvdec_pkg::OP_ADDI;
          3'd1: begin
            op  = rvdec_pkg::OP_SLLI;
            imm = shamt;
          end
          3'd2: op = rvdec_pkg::OP_SLTI;
          3'd3: op = rvdec_pkg::OP_SLTIU;
          3'd4: op = rvdec_pkg::OP_XORI;
          3'd5: begin
            op  = alt ? rvdec_pkg::OP_SRAI : rvdec_pkg::OP_SRLI;
            imm = shamt;
          end
          3'd6: op = rvdec_pkg::OP_ORI;
          default: op = rvdec_pkg::OP_ANDI;
        endcase
      end
      rvdec_pkg::OPC_OP: begin
        if (f7 == rvdec_pkg::F7_MULDIV) begin
          // M operations follow funct3 order from MUL.
          op = rvdec_pkg::OP_MUL + {4'b0, f3};
        end else begin
          case (f3)
            3'd0: op = (f7 != rvdec_pkg::F7_BASE) ? rvdec_pkg::OP_SUB : rvdec_pkg::OP_ADD;
            3'd1: op = rvdec_pkg::OP_SLL;
            3'd2: op = rvdec_pkg::OP_SLT;
            3'd3: op = rvdec_pkg::OP_SLTU;
            3'd4: op = rvdec_pkg::OP_XOR;
            3'd5: op = alt ? rvdec_pkg::OP_SRA : rvdec_pkg::OP_SRL;
            3'd6: op = rvdec_pkg::OP_OR;
            default: op = rvdec_pkg::OP_AND;
          endcase
        end
      end
      rvdec_pkg::OPC_SYSTEM: begin
        op    = rvdec_pkg::OP_ECALL;
        legal = (instruction == rvdec_pkg::ECALL_WORD);
      end
      rvdec_pkg::OPC_OP_IMM32: begin
        case (f3)
          3'd0: begin
            op  = rvdec_pkg::OP_ADDIW;
            imm = imm_i;
          end
          3'd1: begin
            op  = rvdec_pkg::OP_SLLIW;
            imm = shamt;
          end
          3'd5: begin
            op  = alt ? rvdec_pkg::OP_SRAIW : rvdec_pkg::OP_SRLIW;
            imm = shamt;
          end
          default: legal = 1'b0;
        endcase
      end
      rvdec_pkg::OPC_OP32: begin
        case (f3)
          3'd0: begin
            if (f7 == rvdec_pkg::F7_MULDIV) begin
              op = rvdec_pkg::OP_MULW;
            end else if (f7 != rvdec_pkg::F7_BASE) begin
              op = rvdec_pkg::OP_SUBW;
            end else begin
              op = rvdec_pkg::OP_ADDW;
            end
          end
          3'd1: op = rvdec_pkg::OP_SLLW;
          3'd4: op = rvdec_pkg::OP_DIVW;
          3'd5: begin
            if (f7 == rvdec_pkg::F7_MULDIV) begin
              op = rvdec_pkg::OP_DIVUW;
            end else begin
              op = alt ? rvdec_pkg::OP_SRAW : rvdec_pkg::OP_SRLW;
            end
          end
          3'd6: op = rvdec_pkg::OP_REMW;
          3'd7: op = rvdec_pkg::OP_REMUW;
          default: legal = 1'b0;
        endcase
      end
      rvdec_pkg::OPC_LOAD_FP: begin
        op  = rvdec_pkg::OP_FLW;
        imm = imm_i;
      end
      rvdec_pkg::OPC_STORE_FP: begin
        op  = rvdec_pkg::OP_FSW;
        imm = imm_s;
      end
      rvdec_pkg::OPC_FMADD:  op = rvdec_pkg::OP_FMADD_S;
      rvdec_pkg::OPC_FMSUB:  op = rvdec_pkg::OP_FMSUB_S;
      rvdec_pkg::OPC_FNMSUB: op = rvdec_pkg::OP_FNMSUB_S;
      rvdec_pkg::OPC_FNMADD: op = rvdec_pkg::OP_FNMADD_S;
      rvdec_pkg::OPC_OP_FP: begin
        case (f7)
          rvdec_pkg::F7_FADD: op = rvdec_pkg::OP_FADD_S;
          rvdec_pkg::F7_FSUB: op = rvdec_pkg::OP_FSUB_S;
          rvdec_pkg::F7_FMUL: op = rvdec_pkg::OP_FMUL_S;
          rvdec_pkg::F7_FDIV: op = rvdec_pkg::OP_FDIV_S;
          rvdec_pkg::F7_FCVT: begin
            // Only the four integer source types in bits 24:20 are decoded.
            op    = rvdec_pkg::OP_FCVT_S_W + {5'b0, rs2[1:0]};
            legal = (rs2[4:2] == 3'b0);
          end
          default: legal = 1'b0;
        endcase
      end
      default: legal = 1'b0;
    endcase
  end

  // An illegal word carries zero operation and immediate.
  always_comb begin
    result.operation = legal ? op : 7'b0;
    result.immediate = legal ? $signed(imm) : 32'sb0;
    result.illegal   = ~legal;
    result.dest_reg  = instruction[11:7];
    result.src1_reg  = instruction[19:15];
    result.src2_reg  = rs2;
    result.src3_reg  = instruction[31:27];
  end

endmodule

[hdl/rvdec_checker.sv]
// Port-level checks of the RV64IMF decoder and their binding to the top level.
module rvdec_port_checks (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [6:0]         operation,
  input logic [4:0]         dest_reg,
  input logic [4:0]         src1_reg,
  input logic [4:0]         src2_reg,
  input logic [4:0]         src3_reg,
  input logic signed [31:0] immediate,
  input logic               illegal
);

  // An illegal result carries no operation and no immediate.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && illegal |-> operation == 7'b0 && immediate == 32'sb0)
    else $error("illegal result with nonzero operation or immediate");

  // A legal result is one of the decoded operations.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !illegal |-> operation <= rvdec_pkg::OP_LAST)
    else $error("operation number out of range");

  // The input side is held back only while a result waits on a stalled output.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // An accepted request reaches the output once the output side moves.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
    else $error("accepted request did not reach the output");

  // A stalled result stays on the output unchanged.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(operation) && $stable(immediate)
      && $stable(illegal) && $stable(dest_reg) && $stable(src1_reg)
      && $stable(src2_reg) && $stable(src3_reg))
    else $error("stalled result changed");

endmodule

bind rv64imf_instruction_decoder rvdec_port_checks u_rvdec_port_checks (.*);

[tb/rvdec_checker.sv]
// Checker for the RV64IMF decoder: predicts each decoded request and compares every result.
module rvdec_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [31:0]        instruction,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [6:0]         operation,
  input  logic [4:0]         dest_reg,
  input  logic [4:0]         src1_reg,
  input  logic [4:0]         src2_reg,
  input  logic [4:0]         src3_reg,
  input  logic signed [31:0] immediate,
  input  logic               illegal,
  output int                 mismatch_count,
  output int                 pending_count,
  output int                 decoded_count,
  output int                 illegal_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // A decoded request still owed by the block, kept with its word for the report.
  typedef struct packed {
    logic [31:0]            word;
    rvdec_pkg::dec_result_t fields;
  } owed_decode_t;

  owed_decode_t owed_decodes [$];
  owed_decode_t oldest;

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
    decoded_count  = 0;
    illegal_count  = 0;
  end

  // Works out the decoded fields of one instruction word.
  function automatic rvdec_pkg::dec_result_t decode_word(input logic [31:0] w);
    logic [6:0]  opc;
    logic [6:0]  f7;
    logic [6:0]  op;
    logic [2:0]  f3;
    logic [4:0]  rs2;
    logic        alt;
    logic        known;
    logic [31:0] imm;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_u;
    logic [31:0] imm_j;
    logic [31:0] shamt;
    rvdec_pkg::dec_result_t r;
    opc   = w[6:0];
    f3    = w[14:12];
    f7    = w[31:25];
    rs2   = w[24:20];
    alt   = w[30];
    shamt = {26'b0, w[25:20]};
    imm_i = {{21{w[31]}}, w[30:20]};
    imm_s = {{21{w[31]}}, w[30:25], w[11:7]};
    imm_b = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
    imm_u = {w[31:12], 12'b0};
    imm_j = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
    known = 1'b1;
    op    = rvdec_pkg::OP_LUI;
    imm   = '0;

    case (opc)
      rvdec_pkg::OPC_LUI: begin
        op  = rvdec_pkg::OP_LUI;
        imm = imm_u;
      end
      rvdec_pkg::OPC_AUIPC: begin
        op  = rvdec_pkg::OP_AUIPC;
        imm = imm_u;
      end
      rvdec_pkg::OPC_JAL: begin
        op  = rvdec_pkg::OP_JAL;
        imm = imm_j;
      end
      rvdec_pkg::OPC_JALR: begin
        op  = rvdec_pkg::OP_JALR;
        imm = imm_i;
      end
      rvdec_pkg::OPC_BRANCH: begin
        imm = imm_b;
        case (f3)
          3'd0: op = rvdec_pkg::OP_BEQ;
          3'd1: op = rvdec_pkg::OP_BNE;
          3'd4: op = rvdec_pkg::OP_BLT;
          3'd5: op = rvdec_pkg::OP_BGE;
          3'd6: op = rvdec_pkg::OP_BLTU;
          3'd7: op = rvdec_pkg::OP_BGEU;
          default: known = 1'b0;
        endcase
      end
      rvdec_pkg::OPC_LOAD: begin
        // Loads run LB to LWU in funct3 order; the last code is unused.
        imm = imm_i;
        if (f3 == 3'd7) known = 1'b0;
        else op = rvdec_pkg::OP_LB + {4'b0, f3};
      end
      rvdec_pkg::OPC_STORE: begin
        imm = imm_s;
        if (f3[2]) known = 1'b0;
        else op = rvdec_pkg::OP_SB + {4'b0, f3};
      end
      rvdec_pkg::OPC_OP_IMM: begin
        imm = imm_i;
        case (f3)
          3'd0: op = rvdec_pkg::OP_ADDI;
          3'd1: begin
            op  = rvdec_pkg::OP_SLLI;
            imm = shamt;
          end
          3'd2: op = rvdec_pkg::OP_SLTI;
          3'd3: op = rvdec_pkg::OP_SLTIU;
          3'd4: op = rvdec_pkg::OP_XORI;
          3'd5: begin
            op  = alt ? rvdec_pkg::OP_SRAI : rvdec_pkg::OP_SRLI;
            imm = shamt;
          end
          3'd6: op = rvdec_pkg::OP_ORI;
          default: op = rvdec_pkg::OP_ANDI;
        endcase
      end
      rvdec_pkg::OPC_OP: begin
        if (f7 == rvdec_pkg::F7_MULDIV) begin
          op = rvdec_pkg::OP_MUL + {4'b0, f3};
        end else begin
          case (f3)
            3'd0: op = (f7 != rvdec_pkg::F7_BASE) ? rvdec_pkg::OP_SUB : rvdec_pkg::OP_ADD;
            3'd1: op = rvdec_pkg::OP_SLL;
            3'd2: op = rvdec_pkg::OP_SLT;
            3'd3: op = rvdec_pkg::OP_SLTU;
            3'd4: op = rvdec_pkg::OP_XOR;
            3'd5: op = alt ? rvdec_pkg::OP_SRA : rvdec_pkg::OP_SRL;
            3'd6: op = rvdec_pkg::OP_OR;
            default: op = rvdec_pkg::OP_AND;
          endcase
        end
      end
      rvdec_pkg::OPC_SYSTEM: begin
        // Only the bare ECALL word is decoded.
        op    = rvdec_pkg::OP_ECALL;
        known = (w == rvdec_pkg::ECALL_WORD);
      end
      rvdec_pkg::OPC_OP_IMM32: begin
        case (f3)
          3'd0: begin
            op  = rvdec_pkg::OP_ADDIW;
            imm = imm_i;
          end
          3'd1: begin
            op  = rvdec_pkg::OP_SLLIW;
            imm = shamt;
          end
          3'd5: begin
            op  = alt ? rvdec_pkg::OP_SRAIW : rvdec_pkg::OP_SRLIW;
            imm = shamt;
          end
          default: known = 1'b0;
        endcase
      end
      rvdec_pkg::OPC_OP32: begin
        case (f3)
          3'd0: op = (f7 == rvdec_pkg::F7_MULDIV) ? rvdec_pkg::OP_MULW :
                     ((f7 != rvdec_pkg::F7_BASE) ? rvdec_pkg::OP_SUBW : rvdec_pkg::OP_ADDW);
          3'd1: op = rvdec_pkg::OP_SLLW;
          3'd4: op = rvdec_pkg::OP_DIVW;
          3'd5: op = (f7 == rvdec_pkg::F7_MULDIV) ? rvdec_pkg::OP_DIVUW :
                     (alt ? rvdec_pkg::OP_SRAW : rvdec_pkg::OP_SRLW);
          3'd6: op = rvdec_pkg::OP_REMW;
          3'd7: op = rvdec_pkg::OP_REMUW;
          default: known = 1'b0;
        endcase
      end
      rvdec_pkg::OPC_LOAD_FP: begin
        op  = rvdec_pkg::OP_FLW;
        imm = imm_i;
      end
      rvdec_pkg::OPC_STORE_FP: begin
        op  = rvdec_pkg::OP_FSW;
        imm = imm_s;
      end
      rvdec_pkg::OPC_FMADD:  op = rvdec_pkg::OP_FMADD_S;
      rvdec_pkg::OPC_FMSUB:  op = rvdec_pkg::OP_FMSUB_S;
      rvdec_pkg::OPC_FNMSUB: op = rvdec_pkg::OP_FNMSUB_S;
      rvdec_pkg::OPC_FNMADD: op = rvdec_pkg::OP_FNMADD_S;
      rvdec_pkg::OPC_OP_FP: begin
        case (f7)
          rvdec_pkg::F7_FADD: op = rvdec_pkg::OP_FADD_S;
          rvdec_pkg::F7_FSUB: op = rvdec_pkg::OP_FSUB_S;
          rvdec_pkg::F7_FMUL: op = rvdec_pkg::OP_FMUL_S;
          rvdec_pkg::F7_FDIV: op = rvdec_pkg::OP_FDIV_S;
          rvdec_pkg::F7_FCVT: begin
            // The conversion source type sits in the rs2 field.
            if (rs2 <= 5'd3) op = rvdec_pkg::OP_FCVT_S_W + {2'b0, rs2};
            else known = 1'b0;
          end
          default: known = 1'b0;
        endcase
      end
      default: known = 1'b0;
    endcase

    r.operation = known ? op : '0;
    r.immediate = known ? imm : '0;
    r.illegal   = ~known;
    r.dest_reg  = w[11:7];
    r.src1_reg  = w[19:15];
    r.src2_reg  = rs2;
    r.src3_reg  = w[31:27];
    return r;
  endfunction

  // Prints one mismatch and counts it.
  task automatic report_mismatch(input string what, input logic [31:0] word,
                                 input logic [31:0] got, input logic [31:0] want);
    $display("%0t decode mismatch on %s for word %08h: got %0h, expected %0h",
             $realtime, what, word, got, want);
    mismatch_count++;
  endtask

  // Results are matched against the oldest owed request, then new requests are predicted.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (owed_decodes.size() == 0) begin
          report_mismatch("result with no request waiting", 32'h0, {25'b0, operation}, 32'h0);
        end else begin
          oldest = owed_decodes.pop_front();
          decoded_count++;
          if (oldest.fields.illegal) illegal_count++;
          if (operation !== oldest.fields.operation)
            report_mismatch("operation", oldest.word, {25'b0, operation},
                            {25'b0, oldest.fields.operation});
          if (dest_reg !== oldest.fields.dest_reg)
            report_mismatch("dest_reg", oldest.word, {27'b0, dest_reg},
                            {27'b0, oldest.fields.dest_reg});
          if (src1_reg !== oldest.fields.src1_reg)
            report_mismatch("src1_reg", oldest.word, {27'b0, src1_reg},
                            {27'b0, oldest.fields.src1_reg});
          if (src2_reg !== oldest.fields.src2_reg)
            report_mismatch("src2_reg", oldest.word, {27'b0, src2_reg},
                            {27'b0, oldest.fields.src2_reg});
          if (src3_reg !== oldest.fields.src3_reg)
            report_mismatch("src3_reg", oldest.word, {27'b0, src3_reg},
                            {27'b0, oldest.fields.src3_reg});
          if (immediate !== oldest.fields.immediate)
            report_mismatch("immediate", oldest.word, immediate, oldest.fields.immediate);
          if (illegal !== oldest.fields.illegal)
            report_mismatch("illegal", oldest.word, {31'b0, illegal},
                            {31'b0, oldest.fields.illegal});
        end
      end
      if (in_valid && !in_stall) begin
        owed_decodes.push_back('{word: instruction, fields: decode_word(instruction)});
      end
      pending_count = owed_decodes.size();
    end
  end

endmodule

[tb/tb_rv64imf_instruction_decoder.sv]
// Top of the RV64IMF decoder testbench: clock, reset, instruction stimulus and the verdict.
module tb_rv64imf_instruction_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS  = 1600;
  localparam int IDLE_PERCENT  = 32;
  localparam int CALM_FIRST    = 700;
  localparam int CALM_LAST     = 1000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int CYCLE_LIMIT   = 200000;
  // Memory-ordering opcode, which the decoder treats as illegal.
  localparam logic [6:0] OPC_MISC_MEM = 7'b0001111;
  // Alternate funct7 used by SUB, SRA and their word forms.
  localparam logic [6:0] F7_ALT       = 7'b0100000;

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  logic [31:0]        instruction = '0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic [6:0]         operation;
  logic [4:0]         dest_reg;
  logic [4:0]         src1_reg;
  logic [4:0]         src2_reg;
  logic [4:0]         src3_reg;
  logic signed [31:0] immediate;
  logic               illegal;
  logic               calm        = 1'b0;
  int                 cycle_count = 0;
  int                 mismatch_count;
  int                 pending_count;
  int                 decoded_count;
  int                 illegal_count;

  rv64imf_instruction_decoder dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .instruction (instruction),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .operation   (operation),
    .dest_reg    (dest_reg),
    .src1_reg    (src1_reg),
    .src2_reg    (src2_reg),
    .src3_reg    (src3_reg),
    .immediate   (immediate),
    .illegal     (illegal)
  );

  rvdec_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .instruction    (instruction),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .operation      (operation),
    .dest_reg       (dest_reg),
    .src1_reg       (src1_reg),
    .src2_reg       (src2_reg),
    .src3_reg       (src3_reg),
    .immediate      (immediate),
    .illegal        (illegal),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count),
    .decoded_count  (decoded_count),
    .illegal_count  (illegal_count)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // The output side stalls at random, except during the calm stretch.
  always @(posedge clk) begin
    out_stall <= !rst && !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
  end

  // Guard against a hang.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run timed out after %0d cycles with %0d requests owed",
               cycle_count, pending_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offers one request, with random idle cycles first outside the calm stretch, and holds it until it is taken.
  task automatic send_instruction(input logic [31:0] word);
    while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    instruction <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Builds a random word: mostly well-formed encodings with random content, some pure noise.
  function automatic logic [31:0] random_word();
    logic [31:0] w;
    w = $urandom;
    if ($urandom_range(0, 99) >= 10) begin
      case ($urandom_range(0, 20))
        0:  w[6:0] = rvdec_pkg::OPC_LUI;
        1:  w[6:0] = rvdec_pkg::OPC_AUIPC;
        2:  w[6:0] = rvdec_pkg::OPC_JAL;
        3:  w[6:0] = rvdec_pkg::OPC_JALR;
        4:  w[6:0] = rvdec_pkg::OPC_BRANCH;
        5:  w[6:0] = rvdec_pkg::OPC_LOAD;
        6:  w[6:0] = rvdec_pkg::OPC_STORE;
        7:  w[6:0] = rvdec_pkg::OPC_OP_IMM;
        8:  w[6:0] = rvdec_pkg::OPC_OP;
        9:  w[6:0] = rvdec_pkg::OPC_OP_IMM32;
        10: w[6:0] = rvdec_pkg::OPC_OP32;
        11: w[6:0] = rvdec_pkg::OPC_LOAD_FP;
        12: w[6:0] = rvdec_pkg::OPC_STORE_FP;
        13: w[6:0] = rvdec_pkg::OPC_FMADD;
        14: w[6:0] = rvdec_pkg::OPC_FMSUB;
        15: w[6:0] = rvdec_pkg::OPC_FNMSUB;
        16: w[6:0] = rvdec_pkg::OPC_FNMADD;
        17: w[6:0] = rvdec_pkg::OPC_OP_FP;
        18: w[6:0] = rvdec_pkg::OPC_OP_FP;
        19: w[6:0] = rvdec_pkg::OPC_SYSTEM;
        default: w[6:0] = OPC_MISC_MEM;
      endcase
      // Steer the function fields towards the decoded codes.
      if (w[6:0] == rvdec_pkg::OPC_OP || w[6:0] == rvdec_pkg::OPC_OP32) begin
        case ($urandom_range(0, 3))
          0: w[31:25] = rvdec_pkg::F7_BASE;
          1: w[31:25] = rvdec_pkg::F7_MULDIV;
          2: w[31:25] = F7_ALT;
          default: ;
        endcase
      end else if (w[6:0] == rvdec_pkg::OPC_OP_FP) begin
        case ($urandom_range(0, 6))
          0: w[31:25] = rvdec_pkg::F7_FADD;
          1: w[31:25] = rvdec_pkg::F7_FSUB;
          2: w[31:25] = rvdec_pkg::F7_FMUL;
          3: w[31:25] = rvdec_pkg::F7_FDIV;
          4, 5: w[31:25] = rvdec_pkg::F7_FCVT;
          default: ;
        endcase
        if (w[31:25] == rvdec_pkg::F7_FCVT && $urandom_range(0, 3) != 0)
          w[24:20] = 5'($urandom_range(0, 3));
      end else if (w[6:0] == rvdec_pkg::OPC_SYSTEM && $urandom_range(0, 1) == 0) begin
        w = rvdec_pkg::ECALL_WORD;
      end
    end
    return w;
  endfunction

  // Stimulus: directed corner words, then random words, then drain and verdict.
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_instruction(32'h0000_0000);   // all zeros, unknown opcode
    send_instruction(32'hFFFF_FFFF);   // all ones, unknown opcode
    send_instruction(rvdec_pkg::ECALL_WORD);  // the one decoded SYSTEM word
    send_instruction(32'h0010_0073);   // other SYSTEM word
    send_instruction(32'h0FF0_000F);   // FENCE
    send_instruction(32'hFFFF_F0B7);   // LUI with every upper bit set
    send_instruction(32'hFFFF_F06F);   // JAL with every offset bit set
    send_instruction(32'h0000_2063);   // unused branch code
    send_instruction(32'hFE00_FEE3);   // BGEU, negative offset
    send_instruction(32'h0000_7003);   // unused load code
    send_instruction(32'h8000_6003);   // LWU
    send_instruction(32'h0000_4023);   // unused store code
    send_instruction(32'h7FF0_3023);   // SD
    send_instruction(32'h43F0_5013);   // SRAI, widest shift amount
    send_instruction(32'h0000_7033);   // AND
    send_instruction(32'h4000_0033);   // SUB
    send_instruction(32'h0200_7033);   // REMU
    send_instruction(32'h0000_201B);   // unused OP-IMM-32 code
    send_instruction(32'h4000_501B);   // SRAIW
    send_instruction(32'h0000_203B);   // unused OP-32 code
    send_instruction(32'h0200_403B);   // DIVW
    send_instruction(32'h0200_703B);   // REMUW
    send_instruction(32'hD030_0053);   // FCVT.S.LU
    send_instruction(32'hD040_0053);   // conversion with unknown source type
    send_instruction(32'h0200_0053);   // unknown float function code
    send_instruction(32'hFFFF_FFCF);   // FNMADD.S with every field bit set

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= CALM_FIRST && i < CALM_LAST);
      send_instruction(random_word());
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // Let the checker take in the last request, then wait for every result.
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d decoded requests, %0d of them illegal words,", decoded_count,
             illegal_count);
    $display("with random gaps and output stalls around a stretch of full-rate traffic.");
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
